FILE: rtl/wcts_pkg.sv
`timescale 1ns / 1ps

package wcts_pkg;

    // Fixed-point and field widths
    localparam int FRACBITS    = 16;
    localparam int CMD_W       = 2;
    localparam int LIDX_W      = 10;
    localparam int BYTE_W      = 8;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 10;
    localparam int STEP_W      = 31;
    localparam int FRAC_W      = 32;
    localparam int HEIGHT_W    = 11;
    localparam int TIDX_W      = 16;

    // Light map geometry
    localparam int LIGHT_DEPTH = 256;
    localparam int LIGHT_AW    = 8;

    // Default texel column depth
    localparam int TEX_DEPTH_DEF = 1024;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DW    = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT = 1'b0,
        CFG_CENTER = 1'b1
    } t_cfg_idx;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 11'd128;
    localparam logic [ROW_W-1:0]    CENTER_RST = 10'd100;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TEXEL = 2'd0,
        CMD_LOAD_LIGHT = 2'd1,
        CMD_START      = 2'd2,
        CMD_NEXT       = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_ABS,
        ST_DIV,
        ST_FIX,
        ST_QUO,
        ST_ADDR,
        ST_TEX,
        ST_LIGHT
    } t_state;

endpackage

FILE: rtl/wcts_in_if.sv
`timescale 1ns / 1ps

interface wcts_in_if;
    import wcts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [LIDX_W-1:0]        load_index;
    logic [BYTE_W-1:0]        load_value;
    logic [COL_W-1:0]         column_x;
    logic [ROW_W-1:0]         row_top;
    logic [ROW_W-1:0]         row_bottom;
    logic [STEP_W-1:0]        tex_step;
    logic signed [FRAC_W-1:0] tex_middle;

    modport source (
        output valid, cmd, load_index, load_value, column_x, row_top, row_bottom,
               tex_step, tex_middle,
        input  ready
    );

    modport sink (
        input  valid, cmd, load_index, load_value, column_x, row_top, row_bottom,
               tex_step, tex_middle,
        output ready
    );
endinterface

FILE: rtl/wcts_out_if.sv
`timescale 1ns / 1ps

interface wcts_out_if;
    import wcts_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  pixel_x;
    logic [ROW_W-1:0]  pixel_y;
    logic [BYTE_W-1:0] pixel_color;
    logic              last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
        output ready
    );
endinterface

FILE: rtl/wcts_ram.sv
`timescale 1ns / 1ps

module wcts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/wall_column_texture_sampler.sv
`timescale 1ns / 1ps

// Channel   Dir   Handshake            Payload
// i_in      in    valid/ready          cmd, load_index, load_value, column_x, row_top,
//                                      row_bottom, tex_step, tex_middle
// o_out     out   valid/ready          pixel_x, pixel_y, pixel_color, last_pixel
// i_cfg_*   in    write enable only    i_cfg_idx, i_cfg_data
//
// Next pixel: ST_QUO (only when TEX_DEPTH is not a power of two), ST_ADDR, then the chain
// texel RAM read -> light RAM read -> output register; i_in is not ready meanwhile.
// Start: ST_ADD; heights that need the floor modulo add ST_ABS, a 16-step remainder and ST_FIX.
// Texel load: ST_QUO (non-power-of-two depth), ST_ADDR; light load written on transfer.
// Reset is synchronous, active low; RAM contents are not cleared.
// A result waiting in the output register does not block loads or starts; the next pixel
// holds in its last stage until the output register frees.

module wall_column_texture_sampler #(
    parameter int TEX_DEPTH = wcts_pkg::TEX_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wcts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wcts_pkg::CFG_DW-1:0]        i_cfg_data,
    wcts_in_if.sink                            i_in,
    wcts_out_if.source                         o_out
);
    import wcts_pkg::*;

    localparam int  AW         = $clog2(TEX_DEPTH);
    localparam bit  DEPTH_POW2 = (TEX_DEPTH & (TEX_DEPTH - 1)) == 0;
    // Reciprocal for index modulo depth: floor(x / D) ~ (x * RECIP) >> RSH, low by at most 1
    localparam int  RSH        = TIDX_W + AW;
    localparam logic [17:0] RECIP = 18'((64'd1 << RSH) / TEX_DEPTH);

    // State
    t_state r_state, n_state;

    logic [HEIGHT_W-1:0]   r_height;
    logic [ROW_W-1:0]      r_center;
    logic [FRAC_W-1:0]     r_frac;
    logic [ROW_W-1:0]      r_cur_row;
    logic [ROW_W-1:0]      r_end_row;
    logic [COL_W-1:0]      r_cur_col;
    logic [STEP_W-1:0]     r_col_step;
    logic                  r_drawing;

    logic [FRAC_W-1:0]     r_prod;
    logic [FRAC_W-1:0]     r_mid;
    logic                  r_neg;
    logic [HEIGHT_W-1:0]   r_rem;
    logic [3:0]            r_cnt;

    logic [TIDX_W-1:0]     r_tidx;
    logic [TIDX_W-1:0]     r_q;
    logic signed [FRAC_W:0] r_sum;
    logic                  r_is_load;
    logic [BYTE_W-1:0]     r_wdata;
    logic [COL_W-1:0]      r_px_x;
    logic [ROW_W-1:0]      r_px_y;
    logic                  r_px_last;

    logic                  r_out_valid;
    logic [COL_W-1:0]      r_out_x;
    logic [ROW_W-1:0]      r_out_y;
    logic [BYTE_W-1:0]     r_out_color;
    logic                  r_out_last;

    // Control
    logic                  in_xfer;
    logic                  out_free;
    logic                  tex_we, tex_re, light_we, light_re;
    logic [AW-1:0]         tex_waddr, tex_addr;
    logic [BYTE_W-1:0]     tex_rdata, light_rdata;
    t_cmd                  cmd;

    // Height classification
    logic                  h_pow2, h_mod;
    assign h_pow2 = (r_height != '0) && ((r_height & (r_height - 11'd1)) == '0);
    assign h_mod  = (r_height != '0) && !h_pow2;

    assign cmd      = t_cmd'(i_in.cmd);
    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    // Start: (top - center) * step, low 32 bits
    logic signed [COL_W-1:0]  diff;
    logic signed [FRAC_W-1:0] step_s;
    logic signed [42:0]       prod_full;
    assign diff      = $signed({1'b0, i_in.row_top}) - $signed({1'b0, r_center});
    assign step_s    = $signed({1'b0, i_in.tex_step});
    assign prod_full = diff * step_s;

    // Pixel: texel index before depth reduction
    logic [TIDX_W-1:0] hi, pre_idx;
    assign hi      = r_frac[FRAC_W-1:FRACBITS];
    assign pre_idx = h_pow2 ? {5'b0, hi[HEIGHT_W-1:0] & (r_height - 11'd1)} : hi;

    // Accumulator advance with one wrap
    logic signed [FRAC_W:0] hm33;
    logic [FRAC_W:0]        frac_sub;
    logic [FRAC_W-1:0]      frac_next;
    assign hm33      = $signed({6'b0, r_height, 16'b0});
    assign frac_sub  = r_sum - hm33;
    assign frac_next = (h_mod && (r_sum >= hm33)) ? frac_sub[FRAC_W-1:0] : r_sum[FRAC_W-1:0];

    // Remainder step
    logic [HEIGHT_W:0] trial, trial_sub;
    logic              trial_ge;
    assign trial     = {r_rem, r_frac[FRAC_W-1]};
    assign trial_ge  = trial >= {1'b0, r_height};
    assign trial_sub = trial - {1'b0, r_height};

    // Sign fix after remainder
    logic [26:0] remf, hm27, fix_sub;
    assign remf    = {r_rem, r_frac[FRACBITS-1:0]};
    assign hm27    = {r_height, 16'b0};
    assign fix_sub = hm27 - remf;

    // Index modulo depth
    logic [RSH+TIDX_W-1:0] qprod;
    logic [31:0] qd, rr, rr_sub;
    assign qprod  = (RSH+TIDX_W)'(r_tidx) * (RSH+TIDX_W)'(RECIP);
    assign qd     = 32'(r_q) * 32'(TEX_DEPTH);
    assign rr     = 32'(r_tidx) - qd;
    assign rr_sub = rr - 32'(TEX_DEPTH);

    always_comb begin
        if (DEPTH_POW2) begin
            tex_addr = r_tidx[AW-1:0];
        end else begin
            tex_addr = (rr >= 32'(TEX_DEPTH)) ? rr_sub[AW-1:0] : rr[AW-1:0];
        end
    end
    assign tex_waddr = tex_addr;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and memory strobes
    always_comb begin
        n_state  = r_state;
        tex_we   = 1'b0;
        tex_re   = 1'b0;
        light_we = 1'b0;
        light_re = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (cmd)
                        CMD_LOAD_TEXEL: n_state = DEPTH_POW2 ? ST_ADDR : ST_QUO;
                        CMD_LOAD_LIGHT: light_we = 1'b1;
                        CMD_START: begin
                            if (i_in.row_bottom >= i_in.row_top) begin
                                n_state = ST_ADD;
                            end
                        end
                        CMD_NEXT: begin
                            if (r_drawing) begin
                                n_state = DEPTH_POW2 ? ST_ADDR : ST_QUO;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:  n_state = h_mod ? ST_ABS : ST_IDLE;
            ST_ABS:  n_state = ST_DIV;
            ST_DIV:  n_state = (r_cnt == 4'd15) ? ST_FIX : ST_DIV;
            ST_FIX:  n_state = ST_IDLE;
            ST_QUO:  n_state = ST_ADDR;
            ST_ADDR: begin
                if (r_is_load) begin
                    tex_we  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    tex_re  = 1'b1;
                    n_state = ST_TEX;
                end
            end
            ST_TEX: begin
                light_re = 1'b1;
                n_state  = ST_LIGHT;
            end
            ST_LIGHT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HEIGHT_RST;
            r_center <= CENTER_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_CENTER: r_center <= i_cfg_data[ROW_W-1:0];
                default:    r_height <= r_height;
            endcase
        end
    end

    // Column state and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac     <= '0;
            r_cur_row  <= '0;
            r_end_row  <= '0;
            r_cur_col  <= '0;
            r_col_step <= '0;
            r_drawing  <= 1'b0;
            r_cnt      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer && cmd == CMD_START) begin
                        if (i_in.row_bottom < i_in.row_top) begin
                            r_drawing <= 1'b0;
                        end else begin
                            r_cur_row  <= i_in.row_top;
                            r_end_row  <= i_in.row_bottom;
                            r_cur_col  <= i_in.column_x;
                            r_col_step <= i_in.tex_step;
                            r_drawing  <= 1'b1;
                        end
                    end else if (in_xfer && cmd == CMD_NEXT && r_drawing) begin
                        if (r_cur_row == r_end_row) begin
                            r_drawing <= 1'b0;
                        end else begin
                            r_cur_row <= r_cur_row + 10'd1;
                        end
                    end
                end
                ST_ADD: r_frac <= r_mid + r_prod;
                ST_ABS: begin
                    r_frac <= r_frac[FRAC_W-1] ? (~r_frac + 32'd1) : r_frac;
                    r_cnt  <= '0;
                end
                ST_DIV: begin
                    r_frac[FRAC_W-1:FRACBITS] <= {r_frac[FRAC_W-2:FRACBITS], 1'b0};
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_FIX: begin
                    r_frac <= (r_neg && remf != '0) ? 32'(fix_sub) : 32'(remf);
                end
                ST_ADDR: begin
                    if (!r_is_load) begin
                        r_frac <= frac_next;
                    end
                end
                default: r_frac <= r_frac;
            endcase
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    r_prod    <= prod_full[FRAC_W-1:0];
                    r_mid     <= i_in.tex_middle;
                    r_wdata   <= i_in.load_value;
                    r_is_load <= (cmd == CMD_LOAD_TEXEL);
                    r_tidx    <= (cmd == CMD_LOAD_TEXEL) ? {6'b0, i_in.load_index} : pre_idx;
                    r_sum     <= $signed({r_frac[FRAC_W-1], r_frac}) +
                                 $signed({2'b00, r_col_step});
                    r_px_x    <= r_cur_col;
                    r_px_y    <= r_cur_row;
                    r_px_last <= (r_cur_row == r_end_row);
                end
            end
            ST_ABS: begin
                r_neg <= r_frac[FRAC_W-1];
                r_rem <= '0;
            end
            ST_DIV: r_rem <= trial_ge ? trial_sub[HEIGHT_W-1:0] : trial[HEIGHT_W-1:0];
            ST_QUO: r_q   <= qprod[RSH +: TIDX_W];
            default: r_q  <= r_q;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_LIGHT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LIGHT && out_free) begin
            r_out_x     <= r_px_x;
            r_out_y     <= r_px_y;
            r_out_color <= light_rdata;
            r_out_last  <= r_px_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_x     = r_out_x;
    assign o_out.pixel_y     = r_out_y;
    assign o_out.pixel_color = r_out_color;
    assign o_out.last_pixel  = r_out_last;

    // Texel column store
    wcts_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TEX_DEPTH)
    ) u_texel_ram (
        .i_clk   (i_clk),
        .i_we    (tex_we),
        .i_waddr (tex_waddr),
        .i_wdata (r_wdata),
        .i_re    (tex_re),
        .i_raddr (tex_addr),
        .o_rdata (tex_rdata)
    );

    // Light map
    wcts_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LIGHT_DEPTH)
    ) u_light_ram (
        .i_clk   (i_clk),
        .i_we    (light_we),
        .i_waddr (i_in.load_index[LIGHT_AW-1:0]),
        .i_wdata (i_in.load_value),
        .i_re    (light_re),
        .i_raddr (tex_rdata),
        .o_rdata (light_rdata)
    );

    // A pixel leaving the last stage always lands in the output register
    a_light_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIGHT && out_free) |=> r_out_valid)
        else $error("pixel lost at output register");

    // Floor modulo leaves the accumulator inside one texture period
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX) |=> (r_frac < {5'b0, $past(r_height), 16'b0}))
        else $error("start accumulator outside texture period");

    // Current row never runs past the column end while drawing
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drawing |-> (r_cur_row <= r_end_row))
        else $error("row counter past column end");

endmodule
